/* hw/rtl/tpdds_pkg.sv */
// shared types, constants and helpers for the three-phase dds dac feeder
package tpdds_pkg;

  localparam int PHASE_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int REG_W           = 16;
  localparam int NUM_PHASES      = 3;
  localparam int NUM_SLOTS       = 6;

  localparam logic [31:0] PHASE_ONE_INIT   = 32'd0;
  localparam logic [31:0] PHASE_TWO_INIT   = 32'd43690;
  localparam logic [31:0] PHASE_THREE_INIT = 32'd21844;

  localparam logic [REG_W-1:0] PHASE_STEP_RST = 16'd65000;
  localparam logic [REG_W-1:0] AMPLITUDE_RST  = 16'd1;

  localparam logic [3:0]  CMD_WRITE_UPDATE = 4'd3;
  localparam logic [30:0] HALF_PI_Q30      = 31'd1686629713;

  localparam logic [2:0] FIRST_WB_SLOT = 3'd3;
  localparam logic [2:0] LAST_SLOT     = 3'd5;

  typedef enum logic [0:0] {
    CFG_PHASE_STEP = 1'b0,
    CFG_AMPLITUDE  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       vld;
    logic [3:0] chan;
    logic       last;
    logic [1:0] quad;
  } dds_tag_t;

  function automatic logic [3:0] chan_of_slot(input logic [2:0] slot);
    logic [3:0] ch;
    unique case (slot)
      3'd0:    ch = 4'd0;
      3'd1:    ch = 4'd1;
      3'd2:    ch = 4'd2;
      3'd3:    ch = 4'd4;
      3'd4:    ch = 4'd5;
      3'd5:    ch = 4'd6;
      default: ch = 4'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [31:0] phase_init(input logic [1:0] idx);
    logic [31:0] v;
    unique case (idx)
      2'd0:    v = PHASE_ONE_INIT;
      2'd1:    v = PHASE_TWO_INIT;
      2'd2:    v = PHASE_THREE_INIT;
      default: v = PHASE_ONE_INIT;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/tpdds_phase_store.sv */
// slot sequencer and phase accumulator memory with read-modify-write
module tpdds_phase_store #(
  parameter int PHASE_BITS = tpdds_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic                        in_sample_tick,
  output logic                        in_stall,
  input  logic [tpdds_pkg::REG_W-1:0] phase_step,
  output logic [PHASE_BITS-1:0]       phase_o,
  output tpdds_pkg::dds_tag_t         tag_o
);
  import tpdds_pkg::*;

  localparam int SUM_W = ((PHASE_BITS > REG_W) ? PHASE_BITS : REG_W) + 1;

  logic [PHASE_BITS-1:0] mem [0:NUM_PHASES-1];

  logic                  init_r;
  logic [1:0]            init_cnt_r;
  logic                  active_r;
  logic [2:0]            slot_r;
  logic [PHASE_BITS-1:0] rd_r;
  dds_tag_t              tag_r;
  logic                  wb_r;
  logic [1:0]            addr_r;

  logic                  accept;
  logic                  slot_end;
  logic [1:0]            rd_addr;
  logic [SUM_W-1:0]      sum;

  assign slot_end = active_r && (slot_r == LAST_SLOT) && adv;
  assign in_stall = init_r || (active_r && !slot_end);
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = (slot_r >= FIRST_WB_SLOT) ? 2'(slot_r - FIRST_WB_SLOT) : slot_r[1:0];
  assign sum      = SUM_W'(rd_r) + SUM_W'(phase_step);

  // clearing pass after reset, then slot sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= 1'b1;
      init_cnt_r <= 2'd0;
      active_r   <= 1'b0;
      slot_r     <= 3'd0;
    end else begin
      if (init_r) begin
        init_cnt_r <= init_cnt_r + 2'd1;
        if (init_cnt_r == 2'(NUM_PHASES - 1)) begin
          init_r <= 1'b0;
        end
      end
      if (accept) begin
        active_r <= in_sample_tick;
        slot_r   <= 3'd0;
      end else if (slot_end) begin
        active_r <= 1'b0;
        slot_r   <= 3'd0;
      end else if (active_r && adv) begin
        slot_r <= slot_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (adv) begin
      tag_r.vld  <= active_r && !init_r;
      tag_r.chan <= chan_of_slot(slot_r);
      tag_r.last <= (slot_r == LAST_SLOT);
      tag_r.quad <= 2'd0;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r   <= mem[rd_addr];
      wb_r   <= (slot_r >= FIRST_WB_SLOT);
      addr_r <= rd_addr;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (init_r) begin
      mem[init_cnt_r] <= PHASE_BITS'(phase_init(init_cnt_r));
    end else if (adv && tag_r.vld && wb_r) begin
      mem[addr_r] <= sum[PHASE_BITS-1:0];
    end
  end

  assign phase_o = rd_r;
  assign tag_o   = tag_r;

endmodule

/* hw/rtl/tpdds_taylor_term.sv */
// one taylor term of the sine series: two multiplications by x, reciprocal divide, accumulate
module tpdds_taylor_term #(
  parameter int TERM = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  tpdds_pkg::dds_tag_t        tag_i,
  input  logic [31:0]                x_i,
  input  logic [31:0]                t_i,
  input  logic signed [33:0]         s_i,
  output tpdds_pkg::dds_tag_t        tag_o,
  output logic [31:0]                x_o,
  output logic [31:0]                t_o,
  output logic signed [33:0]         s_o
);
  import tpdds_pkg::*;

  localparam logic [31:0] DIV   = 32'(2 * TERM * (2 * TERM + 1));
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / (2 * TERM * (2 * TERM + 1)));
  localparam bit          ODD   = (TERM % 2) == 1;

  dds_tag_t           tag_a_r, tag_b_r, tag_c_r, tag_d_r;
  logic [31:0]        x_a_r, x_b_r, x_c_r, x_d_r;
  logic signed [33:0] s_a_r, s_b_r, s_c_r, s_d_r;
  logic [31:0]        ta_r, tb_r, tc_r, qe_r, q_r;

  logic [63:0]        prod_a, prod_b, prod_c;
  logic [31:0]        rem;
  logic [31:0]        q;

  assign prod_a = 64'(t_i) * 64'(x_i);
  assign prod_b = 64'(ta_r) * 64'(x_a_r);
  assign prod_c = 64'(tb_r) * 64'(RECIP);
  assign rem    = tc_r - 32'(qe_r * DIV);
  assign q      = (rem >= DIV) ? qe_r + 32'd1 : qe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
      tag_d_r <= '0;
    end else if (adv) begin
      tag_a_r <= tag_i;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
      tag_d_r <= tag_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta_r  <= 32'(prod_a >> 30);
      x_a_r <= x_i;
      s_a_r <= s_i;
      tb_r  <= 32'(prod_b >> 30);
      x_b_r <= x_a_r;
      s_b_r <= s_a_r;
      qe_r  <= 32'(prod_c >> 32);
      tc_r  <= tb_r;
      x_c_r <= x_b_r;
      s_c_r <= s_b_r;
      q_r   <= q;
      x_d_r <= x_c_r;
      s_d_r <= ODD ? s_c_r - $signed({2'b00, q}) : s_c_r + $signed({2'b00, q});
    end
  end

  assign tag_o = tag_d_r;
  assign x_o   = x_d_r;
  assign t_o   = q_r;
  assign s_o   = s_d_r;

endmodule

/* hw/rtl/tpdds_sine_pipe.sv */
// pipelined sine unit: quadrant fold, angle scaling, taylor terms, offset and rounding
module tpdds_sine_pipe #(
  parameter int PHASE_BITS  = tpdds_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = tpdds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic [PHASE_BITS-1:0]  phase_i,
  input  tpdds_pkg::dds_tag_t    tag_i,
  output logic [SAMPLE_BITS-1:0] u_o,
  output tpdds_pkg::dds_tag_t    tag_o
);
  import tpdds_pkg::*;

  localparam int NUM_TERMS = 6;
  localparam int OFF_W     = PHASE_BITS - 1;
  localparam int XPROD_W   = OFF_W + 31;
  localparam int H         = SAMPLE_BITS - 1;
  localparam logic [OFF_W-1:0]     QSIZE = OFF_W'(1) << (PHASE_BITS - 2);
  localparam logic [30:0]          ROUND = 31'(1) << (29 - H);
  localparam logic [SAMPLE_BITS:0] HALF  = (SAMPLE_BITS + 1)'(1) << H;
  localparam logic [SAMPLE_BITS:0] FULL  = ((SAMPLE_BITS + 1)'(1) << SAMPLE_BITS) - 1'b1;
  localparam logic signed [33:0]   ONE_Q30 = 34'sd1 << 30;

  dds_tag_t         tag_p1_r, tag_p2_r, tag_p3_r;
  logic [OFF_W-1:0] off_r;
  logic [31:0]      x_r;
  logic [SAMPLE_BITS-1:0] u_r;

  logic [1:0]        quad;
  logic [OFF_W-1:0]  r;
  logic [XPROD_W-1:0] xprod;

  dds_tag_t           tag_c [0:NUM_TERMS];
  logic [31:0]        x_c   [0:NUM_TERMS];
  logic [31:0]        t_c   [0:NUM_TERMS];
  logic signed [33:0] s_c   [0:NUM_TERMS];

  logic [30:0]          mag;
  logic [30:0]          vsum;
  logic [SAMPLE_BITS:0] v;
  logic [SAMPLE_BITS:0] usum;
  logic [SAMPLE_BITS-1:0] u;

  assign quad  = phase_i[PHASE_BITS-1 -: 2];
  assign r     = OFF_W'(phase_i[PHASE_BITS-3:0]);
  assign xprod = XPROD_W'(off_r) * XPROD_W'(HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_p1_r <= '0;
      tag_p2_r <= '0;
      tag_p3_r <= '0;
    end else if (adv) begin
      tag_p1_r <= '{vld: tag_i.vld, chan: tag_i.chan, last: tag_i.last, quad: quad};
      tag_p2_r <= tag_p1_r;
      tag_p3_r <= tag_c[NUM_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      off_r <= quad[0] ? QSIZE - r : r;
      x_r   <= 32'(xprod >> (PHASE_BITS - 2));
      u_r   <= u;
    end
  end

  assign tag_c[0] = tag_p2_r;
  assign x_c[0]   = x_r;
  assign t_c[0]   = x_r;
  assign s_c[0]   = $signed({2'b00, x_r});

  for (genvar k = 1; k <= NUM_TERMS; k++) begin : g_term
    tpdds_taylor_term #(
      .TERM (k)
    ) u_term (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tag_i (tag_c[k-1]),
      .x_i   (x_c[k-1]),
      .t_i   (t_c[k-1]),
      .s_i   (s_c[k-1]),
      .tag_o (tag_c[k]),
      .x_o   (x_c[k]),
      .t_o   (t_c[k]),
      .s_o   (s_c[k])
    );
  end

  // clamp, round to half scale, offset by quadrant
  always_comb begin
    if (s_c[NUM_TERMS] < 0) begin
      mag = '0;
    end else if (s_c[NUM_TERMS] > ONE_Q30) begin
      mag = 31'(ONE_Q30);
    end else begin
      mag = s_c[NUM_TERMS][30:0];
    end
    vsum = mag + ROUND;
    v    = (SAMPLE_BITS + 1)'(vsum >> (30 - H));
    if (!tag_c[NUM_TERMS].quad[1]) begin
      usum = HALF + v;
      u    = (usum > FULL) ? FULL[SAMPLE_BITS-1:0] : usum[SAMPLE_BITS-1:0];
    end else begin
      usum = HALF - v;
      u    = (v > HALF) ? '0 : usum[SAMPLE_BITS-1:0];
    end
  end

  assign u_o   = u_r;
  assign tag_o = tag_p3_r;

endmodule

/* hw/rtl/three_phase_dds_dac_feeder_unit.sv */
// three-phase dds dac feeder: config registers, amplitude scaling and output register
// a tick's first write passes the phase store, sine pipe and output registers, then one
// write per cycle unless out_stall holds it; six writes per tick through the single sine
// pipeline, a new tick waits for the last slot; the phase memory gives each accumulator
// two reads and one write back per tick; reset: synchronous, active low; a clearing pass
// loads the phase memory with in_stall high; config registers return to their reset values
module three_phase_dds_dac_feeder_unit #(
  parameter int PHASE_BITS  = tpdds_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = tpdds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic [0:0]                  cfg_index,
  input  logic [tpdds_pkg::REG_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_sample_tick,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_dac_command,
  output logic [3:0]                  out_dac_channel,
  output logic [15:0]                 out_dac_code,
  output logic                        out_last_of_tick
);
  import tpdds_pkg::*;

  localparam int PROD_W = REG_W + SAMPLE_BITS;

  logic [REG_W-1:0] phase_step_r;
  logic [REG_W-1:0] amplitude_r;
  logic             out_valid_r;
  logic [3:0]       out_chan_r;
  logic             out_last_r;
  logic [15:0]      out_code_r;

  logic                   adv;
  logic [PHASE_BITS-1:0]  phase;
  dds_tag_t               tag_ph;
  logic [SAMPLE_BITS-1:0] u;
  dds_tag_t               tag_u;
  logic [PROD_W-1:0]      prod;

  assign adv  = !out_valid_r || !out_stall;
  assign prod = PROD_W'(amplitude_r) * PROD_W'(u);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      amplitude_r  <= AMPLITUDE_RST;
    end else if (cfg_write_en) begin
      if (cfg_index == CFG_PHASE_STEP) begin
        phase_step_r <= cfg_data;
      end
      if (cfg_index == CFG_AMPLITUDE) begin
        amplitude_r <= cfg_data;
      end
    end
  end

  tpdds_phase_store #(
    .PHASE_BITS (PHASE_BITS)
  ) u_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_sample_tick (in_sample_tick),
    .in_stall       (in_stall),
    .phase_step     (phase_step_r),
    .phase_o        (phase),
    .tag_o          (tag_ph)
  );

  tpdds_sine_pipe #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sine (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .phase_i (phase),
    .tag_i   (tag_ph),
    .u_o     (u),
    .tag_o   (tag_u)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tag_u.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan_r <= tag_u.chan;
      out_last_r <= tag_u.last;
      out_code_r <= prod[SAMPLE_BITS +: 16];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dac_command  = CMD_WRITE_UPDATE;
  assign out_dac_channel  = out_chan_r;
  assign out_dac_code     = out_code_r;
  assign out_last_of_tick = out_last_r;

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the three-phase dds dac feeder unit
`timescale 1ns / 1ps

module tb;
  import tpdds_pkg::*;

  typedef struct {
    logic [3:0]  command;
    logic [3:0]  channel;
    logic [15:0] code;
    logic        last;
  } dac_write_t;

  localparam logic [3:0] CHAN_ORDER [6] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6};

  logic                clk;
  logic                rst_n;
  logic                cfg_write_en;
  logic [0:0]          cfg_index;
  logic [REG_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                in_sample_tick;
  logic                out_valid;
  logic                out_stall;
  logic [3:0]          out_dac_command;
  logic [3:0]          out_dac_channel;
  logic [15:0]         out_dac_code;
  logic                out_last_of_tick;

  dac_write_t  pending_writes [$];
  logic [15:0] step_reg;
  logic [15:0] amp_reg;
  logic [15:0] acc [3];
  int          burst_left;
  int          sent_ticks;
  int          checked_writes;
  int          settings_applied;
  int          mismatch_count;
  int          stall_mode;
  int          mode_left;

  three_phase_dds_dac_feeder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_tick   (in_sample_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dac_command  (out_dac_command),
    .out_dac_channel  (out_dac_channel),
    .out_dac_code     (out_dac_code),
    .out_last_of_tick (out_last_of_tick)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // taylor sine in q2.30, folded into an unsigned 0.16 level, then scaled by amplitude
  function automatic logic [15:0] dac_level_for(input logic [15:0] ph);
    longint unsigned quad, r, off, x, t, mag, v, u;
    longint          s;
    logic [31:0]     prod;
    quad = (ph >> 14) & 64'd3;
    r    = ph & 64'h3fff;
    off  = quad[0] ? (64'd16384 - r) : r;
    x    = (off * 64'(HALF_PI_Q30)) >> 14;
    s    = longint'(x);
    t    = x;
    for (int k = 1; k <= 6; k++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    mag = unsigned'(s);
    v   = (mag + (64'd1 << 14)) >> 15;
    if (quad < 2) u = 64'd32768 + v;
    else u = (v > 64'd32768) ? 64'd0 : 64'd32768 - v;
    if (u > 64'd65535) u = 64'd65535;
    prod = amp_reg * u[15:0];
    return prod[31:16];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on write %0d, %s: got %0d, want %0d", checked_writes, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(input logic tick);
    logic [15:0] codes [3];
    dac_write_t  w;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    in_sample_tick <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (tick) begin
      for (int p = 0; p < 3; p++) codes[p] = dac_level_for(acc[p]);
      for (int k = 0; k < 6; k++) begin
        w.command = CMD_WRITE_UPDATE;
        w.channel = CHAN_ORDER[k];
        w.code    = codes[k % 3];
        w.last    = (k == 5);
        pending_writes.push_back(w);
      end
      for (int p = 0; p < 3; p++) acc[p] = acc[p] + step_reg;
      sent_ticks++;
    end
  endtask

  task automatic drain_writes();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0) @(posedge clk);
    // a tick-less transfer may still be in flight
    repeat (40) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] step, input logic [15:0] amp);
    drain_writes();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_PHASE_STEP;
    cfg_data     <= step;
    @(posedge clk);
    cfg_index    <= CFG_AMPLITUDE;
    cfg_data     <= amp;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    step_reg = step;
    amp_reg  = amp;
    settings_applied++;
  endtask

  task automatic test_reset_defaults();
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
  endtask

  task automatic test_no_tick();
    apply_settings(16'd1000, 16'd40000);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
  endtask

  task automatic test_quadrant_points();
    apply_settings(16'd16384, 16'hffff);
    repeat (5) send_item(1'b1);
  endtask

  task automatic test_step_extremes();
    apply_settings(16'd0, 16'hffff);
    repeat (2) send_item(1'b1);
    apply_settings(16'hffff, 16'd32768);
    repeat (3) send_item(1'b1);
    apply_settings(16'd1, 16'd0);
    repeat (2) send_item(1'b1);
  endtask

  task automatic test_random_settings();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: apply_settings(16'($urandom), 16'hffff);
        1: apply_settings(16'($urandom_range(0, 255)), 16'($urandom));
        2: apply_settings(16'($urandom), 16'($urandom_range(0, 255)));
        default: apply_settings(16'($urandom), 16'($urandom));
      endcase
      target = sent_ticks + 30;
      while (sent_ticks < target) begin
        if (ph == 1 && sent_ticks == target - 15) drain_writes();
        send_item($urandom_range(0, 99) < 88);
      end
    end
  endtask

  // receiver stalls in modes of random length, from free running to mostly held
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    dac_write_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected transfer, channel", out_dac_channel, 0);
      end else begin
        want = pending_writes.pop_front();
        if (out_dac_command !== want.command)
          report_mismatch("dac_command", out_dac_command, want.command);
        if (out_dac_channel !== want.channel)
          report_mismatch("dac_channel", out_dac_channel, want.channel);
        if (out_dac_code !== want.code)
          report_mismatch("dac_code", out_dac_code, want.code);
        if (out_last_of_tick !== want.last)
          report_mismatch("last_of_tick", out_last_of_tick, want.last);
      end
      checked_writes++;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_index      = CFG_PHASE_STEP;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_sample_tick = 1'b0;
    out_stall      = 1'b0;
    step_reg       = PHASE_STEP_RST;
    amp_reg        = AMPLITUDE_RST;
    acc[0]         = PHASE_ONE_INIT[15:0];
    acc[1]         = PHASE_TWO_INIT[15:0];
    acc[2]         = PHASE_THREE_INIT[15:0];
    burst_left       = 0;
    sent_ticks       = 0;
    checked_writes   = 0;
    settings_applied = 0;
    mismatch_count   = 0;
    stall_mode       = 0;
    mode_left        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_no_tick();
    test_quadrant_points();
    test_step_extremes();
    test_random_settings();

    drain_writes();
    $display("run covered %0d sample ticks and %0d dac writes over %0d register settings",
             sent_ticks, checked_writes, settings_applied + 1);
    $display("settings included zero and full-scale amplitude, zero and maximum phase step");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* three_phase_dds_dac_feeder_unit.f */
hw/rtl/tpdds_pkg.sv
hw/rtl/tpdds_phase_store.sv
hw/rtl/tpdds_taylor_term.sv
hw/rtl/tpdds_sine_pipe.sv
hw/rtl/three_phase_dds_dac_feeder_unit.sv
tb/sv/tb.sv
